// File: rtl/core/tmac_pkg.sv
// tmac_pkg: shared constants and sizing functions for the triangle minimum angle check
// used by every module under rtl/core except tmac_queue; depends on nothing else
package tmac_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COS_WIDTH       = 16;
    localparam logic signed [COS_WIDTH-1:0] COS_RESET = 16'sd28378;
    // square of a q1.15 value never exceeds 2**30
    localparam int COS_SQ_WIDTH    = 2 * COS_WIDTH - 1;
    // n^2 * 2^28 against cos^2 * p1 * p2
    localparam int LHS_SHIFT       = 2 * (COS_WIDTH - 1) - 2;
    localparam int MUL_CHUNK       = 32;
    localparam int QUEUE_DEPTH     = 4;

    function automatic int mul_chunks(input int w);
        return (w + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

    function automatic int mul_lat(input int aw, input int bw);
        return mul_chunks(aw) * mul_chunks(bw) + 1;
    endfunction

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/core/tmac_mul.sv
// tmac_mul: pipelined unsigned multiplier, one chunk partial product added per stage
// depends on tmac_pkg for chunk size and chunk counts
module tmac_mul
    import tmac_pkg::*;
#(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int LAT = 2
)(
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int NA = mul_chunks(AW);
    localparam int NB = mul_chunks(BW);
    localparam int NP = NA * NB;
    localparam int PW = AW + BW;
    localparam int XW = PW + 2 * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0] a_pad;
    logic [NB*MUL_CHUNK-1:0] b_pad;
    logic [2*MUL_CHUNK-1:0]  pp_next [0:NP-1];
    logic [2*MUL_CHUNK-1:0]  pp_reg  [0:NP-1][0:NP-1];
    logic [PW-1:0]           term    [0:LAT-2];
    logic [PW-1:0]           acc_reg [0:LAT-1];

    assign a_pad = (NA*MUL_CHUNK)'(a);
    assign b_pad = (NB*MUL_CHUNK)'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i*NB+j] = a_pad[i*MUL_CHUNK +: MUL_CHUNK]
                                * b_pad[j*MUL_CHUNK +: MUL_CHUNK];
            end
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < LAT - 1; gk++)
        begin : g_term
            if (gk < NP)
            begin : g_pp
                localparam int SH = (gk / NB + gk % NB) * MUL_CHUNK;
                logic [XW-1:0] wide;
                assign wide      = XW'(pp_reg[gk][gk]) << SH;
                assign term[gk]  = wide[PW-1:0];
            end
            else
            begin : g_zero
                assign term[gk] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0]  <= pp_next;
            acc_reg[0] <= '0;
            for (int k = 1; k < NP; k++)
            begin
                pp_reg[k] <= pp_reg[k-1];
            end
            for (int k = 1; k < LAT; k++)
            begin
                acc_reg[k] <= acc_reg[k-1] + term[k-1];
            end
        end
    end

    assign p = acc_reg[LAT-1];

endmodule

// File: rtl/core/tmac_front.sv
// tmac_front: takes triangle transfers, forms squared edge lengths and flags degenerate ones
// depends on tmac_pkg; feeds tmac_queue
module tmac_front
    import tmac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [COORD_WIDTH-1:0]     v0_x,
    input  logic [COORD_WIDTH-1:0]     v0_y,
    input  logic [COORD_WIDTH-1:0]     v0_z,
    input  logic [COORD_WIDTH-1:0]     v1_x,
    input  logic [COORD_WIDTH-1:0]     v1_y,
    input  logic [COORD_WIDTH-1:0]     v1_z,
    input  logic [COORD_WIDTH-1:0]     v2_x,
    input  logic [COORD_WIDTH-1:0]     v2_y,
    input  logic [COORD_WIDTH-1:0]     v2_z,
    input  logic                       in_last,
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic [2*COORD_WIDTH+1:0]   len0,
    output logic [2*COORD_WIDTH+1:0]   len1,
    output logic [2*COORD_WIDTH+1:0]   len2,
    output logic                       degen,
    output logic                       last
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = 2 * COORD_WIDTH + 1;
    localparam int EW = 2 * COORD_WIDTH + 2;

    logic signed [DW-1:0]   px [0:2];
    logic signed [DW-1:0]   py [0:2];
    logic signed [DW-1:0]   pz [0:2];
    logic signed [DW-1:0]   diff [0:8];
    logic signed [2*DW-1:0] prod [0:8];
    logic [SW-1:0]          sq_next [0:8];
    logic [SW-1:0]          sq_reg  [0:8];
    logic [EW-1:0]          len_next [0:2];
    logic [EW-1:0]          len_reg  [0:2];
    logic                   degen_next;
    logic                   degen_reg;
    logic                   fa_valid_reg;
    logic                   fb_valid_reg;
    logic                   fa_last_reg;
    logic                   fb_last_reg;
    logic                   adv;

    assign px[0] = {v0_x[COORD_WIDTH-1], v0_x};
    assign py[0] = {v0_y[COORD_WIDTH-1], v0_y};
    assign pz[0] = {v0_z[COORD_WIDTH-1], v0_z};
    assign px[1] = {v1_x[COORD_WIDTH-1], v1_x};
    assign py[1] = {v1_y[COORD_WIDTH-1], v1_y};
    assign pz[1] = {v1_z[COORD_WIDTH-1], v1_z};
    assign px[2] = {v2_x[COORD_WIDTH-1], v2_x};
    assign py[2] = {v2_y[COORD_WIDTH-1], v2_y};
    assign pz[2] = {v2_z[COORD_WIDTH-1], v2_z};

    // edge k runs from vertex k to the next vertex
    always_comb
    begin
        int nb;
        for (int k = 0; k < 3; k++)
        begin
            nb = (k == 2) ? 0 : k + 1;
            diff[3*k]   = px[k] - px[nb];
            diff[3*k+1] = py[k] - py[nb];
            diff[3*k+2] = pz[k] - pz[nb];
        end
        for (int i = 0; i < 9; i++)
        begin
            prod[i]    = diff[i] * diff[i];
            sq_next[i] = prod[i][SW-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            len_next[k] = EW'(sq_reg[3*k]) + EW'(sq_reg[3*k+1]) + EW'(sq_reg[3*k+2]);
        end
        degen_next = (len_next[0] == '0) || (len_next[1] == '0) || (len_next[2] == '0);
    end

    assign adv      = !fb_valid_reg || push_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_valid_reg <= 1'b0;
            fb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fa_valid_reg <= in_valid;
            fb_valid_reg <= fa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg      <= sq_next;
            fa_last_reg <= in_last;
            len_reg     <= len_next;
            degen_reg   <= degen_next;
            fb_last_reg <= fa_last_reg;
        end
    end

    assign push_valid = fb_valid_reg;
    assign len0       = len_reg[0];
    assign len1       = len_reg[1];
    assign len2       = len_reg[2];
    assign degen      = degen_reg;
    assign last       = fb_last_reg;

endmodule

// File: rtl/core/tmac_queue.sv
// tmac_queue: short register queue between the front and back halves
// no package dependencies
module tmac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/tmac_back.sv
// tmac_back: law of cosines test per angle via exact squared compare, result register
// depends on tmac_pkg and tmac_mul; fed from tmac_queue
module tmac_back
    import tmac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2*COORD_WIDTH+1:0]    len0,
    input  logic [2*COORD_WIDTH+1:0]    len1,
    input  logic [2*COORD_WIDTH+1:0]    len2,
    input  logic                        degen,
    input  logic                        last,
    input  logic signed [COS_WIDTH-1:0] cos_th,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_bad,
    output logic [2:0]                  small_angle_mask,
    output logic                        degenerate,
    output logic                        out_last
);

    localparam int EW     = 2 * COORD_WIDTH + 2;
    localparam int NW     = 2 * COORD_WIDTH + 4;
    localparam int MW     = 2 * COORD_WIDTH + 3;
    localparam int PPW    = 2 * EW;
    localparam int RW     = PPW + COS_SQ_WIDTH;
    localparam int LW     = 2 * MW + LHS_SHIFT;
    localparam int CMPW   = max2(RW, LW);
    localparam int LAT_PP = mul_lat(EW, EW);
    localparam int NAT_C  = mul_lat(PPW, COS_SQ_WIDTH);
    localparam int NAT_SQ = mul_lat(MW, MW);
    localparam int TC     = max2(NAT_SQ + 2, LAT_PP + NAT_C);
    localparam int LAT_C  = TC - LAT_PP;
    localparam int LAT_SQ = TC - 2;

    typedef struct packed {
        logic       degen;
        logic       last;
        logic [2:0] neg;
        logic [2:0] pos;
    } side_t;

    logic [TC+1:0]              bv_reg;
    logic                       adv;
    logic [EW-1:0]              len_reg [0:2];
    logic                       degen0_reg;
    logic                       last0_reg;
    logic signed [NW-1:0]       n_next [0:2];
    logic signed [NW-1:0]       n_reg  [0:2];
    logic                       degen1_reg;
    logic                       last1_reg;
    logic [NW-1:0]              abs_full [0:2];
    logic [MW-1:0]              mag_next [0:2];
    logic [MW-1:0]              mag_reg  [0:2];
    side_t                      side_next;
    side_t                      side_reg [2:TC];
    logic signed [2*COS_WIDTH-1:0] c2_full;
    logic [COS_SQ_WIDTH-1:0]    c2_reg;
    logic [2*MW-1:0]            sq_out [0:2];
    logic [PPW-1:0]             pp_out [0:2];
    logic [RW-1:0]              c_out  [0:2];
    logic [CMPW-1:0]            lhs [0:2];
    logic [CMPW-1:0]            rhs [0:2];
    logic [2:0]                 mask_next;
    logic                       bad_reg;
    logic [2:0]                 mask_reg;
    logic                       degen_out_reg;
    logic                       last_out_reg;

    assign adv      = !bv_reg[TC+1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
        end
        else if (adv)
        begin
            bv_reg <= {bv_reg[TC:0], in_valid};
        end
    end

    // the user must change the threshold only while nothing is in flight; the block does not enforce it
    assign c2_full = cos_th * cos_th;

    always_ff @(posedge clk)
    begin
        c2_reg <= c2_full[COS_SQ_WIDTH-1:0];
    end

    // n for the angle opposite edge k: sum of the other two minus edge k
    always_comb
    begin
        n_next[0] = $signed(NW'(len_reg[1]) + NW'(len_reg[2]) - NW'(len_reg[0]));
        n_next[1] = $signed(NW'(len_reg[0]) + NW'(len_reg[2]) - NW'(len_reg[1]));
        n_next[2] = $signed(NW'(len_reg[0]) + NW'(len_reg[1]) - NW'(len_reg[2]));
        side_next.degen = degen1_reg;
        side_next.last  = last1_reg;
        for (int k = 0; k < 3; k++)
        begin
            abs_full[k]       = n_reg[k][NW-1] ? (NW'(0) - n_reg[k]) : n_reg[k];
            mag_next[k]       = abs_full[k][MW-1:0];
            side_next.neg[k]  = n_reg[k][NW-1];
            side_next.pos[k]  = !n_reg[k][NW-1] && (n_reg[k] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[0]  <= len0;
            len_reg[1]  <= len1;
            len_reg[2]  <= len2;
            degen0_reg  <= degen;
            last0_reg   <= last;
            n_reg       <= n_next;
            degen1_reg  <= degen0_reg;
            last1_reg   <= last0_reg;
            mag_reg     <= mag_next;
            side_reg[2] <= side_next;
            for (int s = 3; s <= TC; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_angle
            localparam int IA = (gk == 0) ? 1 : 0;
            localparam int IB = (gk == 2) ? 1 : 2;

            tmac_mul #(
                .AW  (MW),
                .BW  (MW),
                .LAT (LAT_SQ)
            ) u_sq (
                .clk (clk),
                .en  (adv),
                .a   (mag_reg[gk]),
                .b   (mag_reg[gk]),
                .p   (sq_out[gk])
            );

            tmac_mul #(
                .AW  (EW),
                .BW  (EW),
                .LAT (LAT_PP)
            ) u_pp (
                .clk (clk),
                .en  (adv),
                .a   (len_reg[IA]),
                .b   (len_reg[IB]),
                .p   (pp_out[gk])
            );

            tmac_mul #(
                .AW  (PPW),
                .BW  (COS_SQ_WIDTH),
                .LAT (LAT_C)
            ) u_cos (
                .clk (clk),
                .en  (adv),
                .a   (pp_out[gk]),
                .b   (c2_reg),
                .p   (c_out[gk])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lhs[k] = CMPW'(sq_out[k]) << LHS_SHIFT;
            rhs[k] = CMPW'(c_out[k]);
            if (side_reg[TC].degen)
            begin
                mask_next[k] = 1'b0;
            end
            else if (cos_th[COS_WIDTH-1])
            begin
                mask_next[k] = !side_reg[TC].neg[k] || (lhs[k] < rhs[k]);
            end
            else
            begin
                mask_next[k] = side_reg[TC].pos[k] && (lhs[k] > rhs[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad_reg       <= (mask_next != 3'b000);
            mask_reg      <= mask_next;
            degen_out_reg <= side_reg[TC].degen;
            last_out_reg  <= side_reg[TC].last;
        end
    end

    assign out_valid        = bv_reg[TC+1];
    assign is_bad           = bad_reg;
    assign small_angle_mask = mask_reg;
    assign degenerate       = degen_out_reg;
    assign out_last         = last_out_reg;

endmodule

// File: rtl/core/triangle_min_angle_check.sv
// triangle_min_angle_check: top level, threshold register, front, queue and back halves
// depends on tmac_pkg, tmac_front, tmac_queue, tmac_back
// the back half's pipeline depth at COORD_WIDTH 16 is set by the chain of
// 32-bit partial-product multipliers (edge product, then cosine square), one add per stage
// throughput: one triangle per cycle while out_ready holds; queue of 4 lets either side stall on its own
// reset: rst_n clears all valid and queue state and loads min_angle_cos with 28378
module triangle_min_angle_check
    import tmac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COS_WIDTH-1:0]   cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] v0_x,
    input  logic [COORD_WIDTH-1:0] v0_y,
    input  logic [COORD_WIDTH-1:0] v0_z,
    input  logic [COORD_WIDTH-1:0] v1_x,
    input  logic [COORD_WIDTH-1:0] v1_y,
    input  logic [COORD_WIDTH-1:0] v1_z,
    input  logic [COORD_WIDTH-1:0] v2_x,
    input  logic [COORD_WIDTH-1:0] v2_y,
    input  logic [COORD_WIDTH-1:0] v2_z,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_bad,
    output logic [2:0]             small_angle_mask,
    output logic                   degenerate,
    output logic                   out_last
);

    localparam int EW = 2 * COORD_WIDTH + 2;
    localparam int QW = 3 * EW + 2;

    logic signed [COS_WIDTH-1:0] min_angle_cos_reg;
    logic                        f_valid;
    logic                        f_ready;
    logic [EW-1:0]               f_len0;
    logic [EW-1:0]               f_len1;
    logic [EW-1:0]               f_len2;
    logic                        f_degen;
    logic                        f_last;
    logic [QW-1:0]               q_in;
    logic [QW-1:0]               q_out;
    logic                        q_valid;
    logic                        q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_cos_reg <= COS_RESET;
        end
        else if (cfg_we)
        begin
            min_angle_cos_reg <= $signed(cfg_wdata);
        end
    end

    tmac_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v0_z       (v0_z),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v1_z       (v1_z),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .v2_z       (v2_z),
        .in_last    (in_last),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .len0       (f_len0),
        .len1       (f_len1),
        .len2       (f_len2),
        .degen      (f_degen),
        .last       (f_last)
    );

    assign q_in = {f_len2, f_len1, f_len0, f_degen, f_last};

    tmac_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    tmac_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_ready         (q_ready),
        .len0             (q_out[EW+1:2]),
        .len1             (q_out[2*EW+1:EW+2]),
        .len2             (q_out[3*EW+1:2*EW+2]),
        .degen            (q_out[1]),
        .last             (q_out[0]),
        .cos_th           (min_angle_cos_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_bad           (is_bad),
        .small_angle_mask (small_angle_mask),
        .degenerate       (degenerate),
        .out_last         (out_last)
    );

endmodule

// File: tb/tb_triangle_min_angle_check.sv
`timescale 1ns / 1ps
// tb_triangle_min_angle_check: self-checking testbench for the triangle minimum angle check
// streams triangles over valid/ready, predicts the quality flags and checks them in order
// depends on tmac_pkg and triangle_min_angle_check
module tb_triangle_min_angle_check;
    import tmac_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [8:0][15:0] crd;
        logic             last;
    } tri_item_t;

    typedef struct packed {
        logic       is_bad;
        logic [2:0] mask;
        logic       degen;
        logic       last;
    } tri_flags_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [COS_WIDTH-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    tri_item_t            cur_item  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 is_bad;
    logic [2:0]           small_angle_mask;
    logic                 degenerate;
    logic                 out_last;

    tri_item_t            tri_pending[$];
    tri_flags_t           flags_due[$];
    logic signed [15:0]   cos_thr = COS_RESET;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_token = 0;
    int                   hold_taken = 0;
    int                   hold_left  = 0;
    int                   mismatches = 0;
    int                   results_seen = 0;
    tri_flags_t           got_flags;
    tri_flags_t           want_flags;

    triangle_min_angle_check u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .v0_x             (cur_item.crd[0]),
        .v0_y             (cur_item.crd[1]),
        .v0_z             (cur_item.crd[2]),
        .v1_x             (cur_item.crd[3]),
        .v1_y             (cur_item.crd[4]),
        .v1_z             (cur_item.crd[5]),
        .v2_x             (cur_item.crd[6]),
        .v2_y             (cur_item.crd[7]),
        .v2_z             (cur_item.crd[8]),
        .in_last          (cur_item.last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_bad           (is_bad),
        .small_angle_mask (small_angle_mask),
        .degenerate       (degenerate),
        .out_last         (out_last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint edge_sq(tri_item_t t, int i, int j);
        longint d;
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'($signed(t.crd[3*i+k])) - longint'($signed(t.crd[3*j+k]));
            acc += d * d;
        end
        return acc;
    endfunction

    // exact squared form of n / (2 sqrt(p1 p2)) > cth / 2^15
    function automatic logic angle_is_small(longint n, longint p1, longint p2,
                                            logic signed [15:0] cth);
        logic [127:0] w_n;
        logic [127:0] w_p1;
        logic [127:0] w_p2;
        logic [127:0] w_c2;
        logic [127:0] lhs;
        logic [127:0] rhs;
        w_n  = (n < 0) ? -n : n;
        w_p1 = p1;
        w_p2 = p2;
        w_c2 = longint'(cth) * longint'(cth);
        lhs  = (w_n * w_n) << LHS_SHIFT;
        rhs  = w_p1 * w_p2 * w_c2;
        if (cth >= 0)
            return (n > 0) && (lhs > rhs);
        return (n >= 0) || (lhs < rhs);
    endfunction

    function automatic tri_flags_t predict_flags(tri_item_t t, logic signed [15:0] cth);
        tri_flags_t f;
        longint     ea;
        longint     eb;
        longint     ec;
        ea = edge_sq(t, 0, 1);
        eb = edge_sq(t, 1, 2);
        ec = edge_sq(t, 2, 0);
        f = '0;
        f.last  = t.last;
        f.degen = (ea == 0) || (eb == 0) || (ec == 0);
        if (!f.degen)
        begin
            f.mask[0] = angle_is_small(eb + ec - ea, eb, ec, cth);
            f.mask[1] = angle_is_small(ea + ec - eb, ea, ec, cth);
            f.mask[2] = angle_is_small(ea + eb - ec, ea, eb, cth);
        end
        f.is_bad = |f.mask;
        return f;
    endfunction

    function automatic tri_item_t random_triangle();
        tri_item_t   t;
        int          kind;
        int          spread;
        int          a;
        int          b;
        logic [15:0] base [3];
        kind   = $urandom_range(99);
        spread = 4 << (4 * $urandom_range(3));
        for (int k = 0; k < 3; k++)
            base[k] = 16'($urandom);
        for (int i = 0; i < 9; i++)
            t.crd[i] = base[i % 3] + 16'($urandom_range(2 * spread) - spread);
        if (kind < 35)
        begin
            for (int i = 0; i < 9; i++)
                t.crd[i] = 16'($urandom);
        end
        else if (kind < 75)
        begin
            // local cluster, keeps angles spread around the threshold
        end
        else if (kind < 85)
        begin
            a = $urandom_range(2);
            b = (a + 1 + $urandom_range(1)) % 3;
            for (int k = 0; k < 3; k++)
                t.crd[3*b+k] = t.crd[3*a+k];
        end
        else if (kind < 93)
        begin
            // nearly collinear sliver
            for (int k = 0; k < 3; k++)
                t.crd[6+k] = t.crd[k] + 16'd2 * (t.crd[3+k] - t.crd[k])
                             + 16'($urandom_range(2)) - 16'd1;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
            begin
                case ($urandom_range(3))
                    0:       t.crd[i] = 16'h8000;
                    1:       t.crd[i] = 16'h7FFF;
                    2:       t.crd[i] = 16'h0000;
                    default: t.crd[i] = 16'hFFFF;
                endcase
            end
        end
        t.last = ($urandom_range(7) == 0);
        return t;
    endfunction

    task automatic queue_triangle(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                  input bit last);
        tri_item_t t;
        t.crd[0] = ax[15:0];
        t.crd[1] = ay[15:0];
        t.crd[2] = az[15:0];
        t.crd[3] = bx[15:0];
        t.crd[4] = by[15:0];
        t.crd[5] = bz[15:0];
        t.crd[6] = cx[15:0];
        t.crd[7] = cy[15:0];
        t.crd[8] = cz[15:0];
        t.last   = last;
        tri_pending.push_back(t);
    endtask

    task automatic queue_directed();
        queue_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_triangle(0, 0, 0, 0, 0, 0, 5, 0, 0, 1'b0);
        queue_triangle(0, 0, 0, 5, 0, 0, 5, 0, 0, 1'b1);
        queue_triangle(3, 4, 5, 7, 0, 0, 3, 4, 5, 1'b0);
        queue_triangle(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0);
        queue_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0);
        queue_triangle(0, 0, 0, 1000, 0, 0, 0, 1, 0, 1'b1);
        queue_triangle(0, 0, 0, 1, 0, 0, 2, 0, 0, 1'b0);
        queue_triangle(0, 0, 0, 2, 0, 0, 1, 0, 0, 1'b0);
        queue_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                       32767, -32768, -32768, 1'b0);
        queue_triangle(32767, 32767, 32767, -32768, -32768, -32768,
                       -32768, 32767, 0, 1'b1);
        queue_triangle(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 1'b0);
        queue_triangle(32767, 32767, 32767, 32767, 32767, 32767,
                       32767, 32767, 32767, 1'b0);
        queue_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768, 1'b1);
        queue_triangle(0, 0, 0, 0, -32768, 0, 32767, 0, 0, 1'b0);
        queue_triangle(0, 0, 0, 1732, 0, 0, 1732, 1000, 0, 1'b0);
        queue_triangle(0, 0, 0, 1000, 0, 0, 1000, 577, 0, 1'b0);
        queue_triangle(0, 0, 0, 100, 0, 0, 50, 10, 0, 1'b0);
        queue_triangle(-1, -1, -1, 1, 1, -1, 1, -1, 1, 1'b1);
        queue_triangle(-1, -1, -1, -1, -1, 0, 0, -1, -1, 1'b0);
        queue_triangle(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32766, 1'b1);
    endtask

    task automatic set_threshold(input logic signed [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cos_thr = v;
        @(negedge clk);
    endtask

    task automatic run_phase(input int n_rand, input int send_pct, input int recv_pct,
                             input bit hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_token++;
        for (int i = 0; i < n_rand; i++)
            tri_pending.push_back(random_triangle());
        while (tri_pending.size() > 0 || in_valid || flags_due.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // transfer driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cur_item <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                flags_due.push_back(predict_flags(cur_item, cos_thr));
            if (!in_valid || in_ready)
            begin
                if (tri_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item <= tri_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_flags = {is_bad, small_angle_mask, degenerate, out_last};
                if (flags_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d: bad=%b mask=%b degen=%b last=%b",
                                 results_seen, got_flags.is_bad, got_flags.mask,
                                 got_flags.degen, got_flags.last);
                end
                else
                begin
                    want_flags = flags_due.pop_front();
                    if (got_flags.is_bad !== want_flags.is_bad
                        || got_flags.mask !== want_flags.mask
                        || got_flags.degen !== want_flags.degen
                        || got_flags.last !== want_flags.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at result %0d: expected bad=%b mask=%b ",
                                      "degen=%b last=%b, got bad=%b mask=%b degen=%b last=%b"},
                                     results_seen, want_flags.is_bad, want_flags.mask,
                                     want_flags.degen, want_flags.last, got_flags.is_bad,
                                     got_flags.mask, got_flags.degen, got_flags.last);
                    end
                end
                results_seen++;
            end
            if (hold_token != hold_taken)
            begin
                hold_taken = hold_token;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        run_phase(150, 0, 0, 1'b0);
        set_threshold(16'sh7FFF);
        run_phase(150, 69, 0, 1'b0);
        set_threshold(16'sh8000);
        run_phase(150, 0, 69, 1'b0);
        set_threshold(16'sh0000);
        run_phase(150, 36, 36, 1'b0);
        set_threshold(16'($urandom));
        run_phase(150, 0, 0, 1'b1);
        set_threshold(16'(0 - $urandom_range(32768)));
        run_phase(150, 36, 36, 1'b0);
        set_threshold(16'sd16384);
        run_phase(150, 0, 69, 1'b0);
        if (mismatches == 0 && flags_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tmac_pkg.sv
rtl/core/tmac_mul.sv
rtl/core/tmac_front.sv
rtl/core/tmac_queue.sv
rtl/core/tmac_back.sv
rtl/core/triangle_min_angle_check.sv
tb/tb_triangle_min_angle_check.sv
